[design/kdl_pkg.sv]
// shared widths, codes and control types for the keyed doubly linked list
`default_nettype none

package kdl_pkg;

    localparam int KEY_W = 10;
    localparam int ACT_W = 3;
    localparam int STS_W = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INS_AFTER  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_BEFORE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ASK_NEXT   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ASK_PREV   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DELETE     = 3'd4;

    // status codes
    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL    = 2'd1;
    localparam logic [STS_W-1:0] STS_ABSENT  = 2'd2;
    localparam logic [STS_W-1:0] STS_BAD_KEY = 2'd3;

    // write strobes into the node store
    typedef struct packed {
        logic map;
        logic key;
        logic prev;
        logic next;
    } store_we_t;

endpackage

`default_nettype wire

[design/kdl_if.sv]
// request and response channel interfaces
`default_nettype none

interface kdl_req_if;
    logic                           valid;
    logic                           ready;
    logic [kdl_pkg::ACT_W-1:0]      action;
    logic [kdl_pkg::KEY_W-1:0]      anchor_key;
    logic [kdl_pkg::KEY_W-1:0]      new_key;

    modport source (output valid, output action, output anchor_key, output new_key,
                    input ready);
    modport sink   (input valid, input action, input anchor_key, input new_key,
                    output ready);
endinterface

interface kdl_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [kdl_pkg::STS_W-1:0]      status;
    logic [kdl_pkg::KEY_W-1:0]      neighbor_key;

    modport source (output valid, output status, output neighbor_key, input ready);
    modport sink   (input valid, input status, input neighbor_key, output ready);
endinterface

`default_nettype wire

[design/kdl_store.sv]
// node store: key map plus prev, next and key arrays, one write and one read port each
`default_nettype none

module kdl_store #(
    parameter int SW = 10,
    parameter int KW = 10,
    parameter int SLOT_DEPTH = 1024,
    parameter int KEY_DEPTH = 1024
) (
    input  wire logic                       clk,
    input  wire kdl_pkg::store_we_t         we,
    input  wire logic [KW-1:0]              map_raddr,
    input  wire logic [KW-1:0]              map_waddr,
    input  wire logic [SW-1:0]              map_wdata,
    output logic      [SW-1:0]              map_rdata,
    input  wire logic [SW-1:0]              slot_raddr,
    input  wire logic [SW-1:0]              key_raddr,
    input  wire logic [SW-1:0]              key_waddr,
    input  wire logic [kdl_pkg::KEY_W-1:0]  key_wdata,
    output logic      [kdl_pkg::KEY_W-1:0]  key_rdata,
    input  wire logic [SW-1:0]              prev_waddr,
    input  wire logic [SW-1:0]              prev_wdata,
    output logic      [SW-1:0]              prev_rdata,
    input  wire logic [SW-1:0]              next_waddr,
    input  wire logic [SW-1:0]              next_wdata,
    output logic      [SW-1:0]              next_rdata
);

    logic [SW-1:0]             map_mem  [KEY_DEPTH];
    logic [kdl_pkg::KEY_W-1:0] key_mem  [SLOT_DEPTH];
    logic [SW-1:0]             prev_mem [SLOT_DEPTH];
    logic [SW-1:0]             next_mem [SLOT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we.map)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.key)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rdata <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.prev)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        prev_rdata <= prev_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.next)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_rdata <= next_mem[slot_raddr];
    end

endmodule

`default_nettype wire

[design/keyed_doubly_linked_list.sv]
// keyed doubly linked list: sequencer over the node store
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    action, anchor_key, new_key
//  rsp      out  valid/ready    status, neighbor_key
//
// every item is a short sequence on the store ports: map read, slot read, then writes
// (inserts, delete) or a key read (asks); rejected items stop after the slot read
// the response register frees the sequencer; a held response delays only the next finish
// after reset the key map is cleared, one entry a cycle, all min(KEY_COUNT, 1024) entries
// req.ready stays low during that pass and while an item is in flight
`default_nettype none

module keyed_doubly_linked_list #(
    parameter int KEY_COUNT = 1024,
    parameter int SLOT_COUNT = 1024
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kdl_req_if.sink    req,
    kdl_rsp_if.source  rsp
);

    localparam int KEY_SPAN  = 1 << kdl_pkg::KEY_W;
    localparam int KEY_DEPTH = (KEY_COUNT < KEY_SPAN) ? KEY_COUNT : KEY_SPAN;
    localparam int KW = $clog2(KEY_DEPTH);
    localparam int SW = $clog2(SLOT_COUNT);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_LOOK  = 8'b0000_0100,
        ST_LINK  = 8'b0000_1000,
        ST_W2    = 8'b0001_0000,
        ST_NBR   = 8'b0010_0000,
        ST_NBR2  = 8'b0100_0000,
        ST_RESP  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [kdl_pkg::ACT_W-1:0] act_reg, act_next;
    logic [kdl_pkg::KEY_W-1:0] anchor_reg, anchor_next;
    logic [kdl_pkg::KEY_W-1:0] nkey_reg, nkey_next;
    logic [SW-1:0]             here_reg, here_next;
    logic [SW-1:0]             left_reg, left_next;
    logic [SW-1:0]             right_reg, right_next;
    logic [SW-1:0]             used_reg, used_next;
    logic [KW-1:0]             clr_reg, clr_next;
    logic [kdl_pkg::STS_W-1:0] sts_reg, sts_next;
    logic [kdl_pkg::KEY_W-1:0] nb_reg, nb_next;

    logic                      rsp_valid_reg;
    logic [kdl_pkg::STS_W-1:0] rsp_status_reg;
    logic [kdl_pkg::KEY_W-1:0] rsp_nb_reg;

    // store ports
    kdl_pkg::store_we_t        we;
    logic [KW-1:0]             map_raddr, map_waddr;
    logic [SW-1:0]             map_wdata, map_rdata;
    logic [SW-1:0]             slot_raddr, key_raddr, key_waddr;
    logic [kdl_pkg::KEY_W-1:0] key_wdata, key_rdata;
    logic [SW-1:0]             prev_waddr, prev_wdata, prev_rdata;
    logic [SW-1:0]             next_waddr, next_wdata, next_rdata;

    logic          anchor_ok, nkey_ok, full, rsp_free, is_after;
    logic [SW-1:0] here_c, fresh, left_c, right_c;

    kdl_store #(
        .SW         (SW),
        .KW         (KW),
        .SLOT_DEPTH (SLOT_COUNT),
        .KEY_DEPTH  (KEY_DEPTH)
    ) u_store (
        .clk        (clk),
        .we         (we),
        .map_raddr  (map_raddr),
        .map_waddr  (map_waddr),
        .map_wdata  (map_wdata),
        .map_rdata  (map_rdata),
        .slot_raddr (slot_raddr),
        .key_raddr  (key_raddr),
        .key_waddr  (key_waddr),
        .key_wdata  (key_wdata),
        .key_rdata  (key_rdata),
        .prev_waddr (prev_waddr),
        .prev_wdata (prev_wdata),
        .prev_rdata (prev_rdata),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .next_rdata (next_rdata)
    );

    assign anchor_ok = (32'(anchor_reg) < 32'(KEY_COUNT));
    assign nkey_ok   = (nkey_reg != '0) && (32'(nkey_reg) < 32'(KEY_COUNT));
    assign full      = (used_reg == SW'(SLOT_COUNT - 1));
    assign here_c    = anchor_ok ? map_rdata : '0;
    assign fresh     = used_reg + SW'(1);
    assign is_after  = (act_reg == kdl_pkg::ACT_INS_AFTER);
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    // neighbors of the new node, or of the node being removed
    always_comb
    begin
        if (act_reg == kdl_pkg::ACT_DELETE)
        begin
            left_c  = prev_rdata;
            right_c = next_rdata;
        end
        else
        begin
            left_c  = is_after ? here_reg : prev_rdata;
            right_c = is_after ? next_rdata : here_reg;
        end
    end

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        anchor_next = anchor_reg;
        nkey_next   = nkey_reg;
        here_next   = here_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        used_next   = used_reg;
        clr_next    = clr_reg;
        sts_next    = sts_reg;
        nb_next     = nb_reg;

        we          = '0;
        map_raddr   = anchor_reg[KW-1:0];
        map_waddr   = clr_reg;
        map_wdata   = '0;
        slot_raddr  = here_reg;
        key_raddr   = '0;
        key_waddr   = '0;
        key_wdata   = '0;
        prev_waddr  = '0;
        prev_wdata  = '0;
        next_waddr  = '0;
        next_wdata  = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we.map   = 1'b1;
                clr_next = clr_reg + KW'(1);
                // sentinel slot starts as an empty ring
                if (clr_reg == '0)
                begin
                    we.key  = 1'b1;
                    we.prev = 1'b1;
                    we.next = 1'b1;
                end
                if (clr_reg == KW'(KEY_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                map_raddr = req.anchor_key[KW-1:0];
                if (req.valid)
                begin
                    act_next    = req.action;
                    anchor_next = req.anchor_key;
                    nkey_next   = req.new_key;
                    sts_next    = kdl_pkg::STS_OK;
                    nb_next     = '0;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                slot_raddr = here_c;
                here_next  = here_c;
                case (act_reg) inside
                    kdl_pkg::ACT_INS_AFTER, kdl_pkg::ACT_INS_BEFORE:
                    begin
                        if (!nkey_ok)
                        begin
                            sts_next   = kdl_pkg::STS_BAD_KEY;
                            state_next = ST_RESP;
                        end
                        else if (full)
                        begin
                            sts_next   = kdl_pkg::STS_FULL;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_LINK;
                        end
                    end
                    kdl_pkg::ACT_ASK_NEXT, kdl_pkg::ACT_ASK_PREV:
                    begin
                        state_next = ST_NBR;
                    end
                    kdl_pkg::ACT_DELETE:
                    begin
                        if (here_c == '0)
                        begin
                            sts_next   = kdl_pkg::STS_ABSENT;
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_LINK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_LINK:
            begin
                we.map     = 1'b1;
                we.prev    = 1'b1;
                we.next    = 1'b1;
                left_next  = left_c;
                right_next = right_c;
                if (act_reg == kdl_pkg::ACT_DELETE)
                begin
                    // unlink the node and drop its key
                    map_waddr  = anchor_reg[KW-1:0];
                    map_wdata  = '0;
                    next_waddr = left_c;
                    next_wdata = right_c;
                    prev_waddr = right_c;
                    prev_wdata = left_c;
                    state_next = ST_RESP;
                end
                else
                begin
                    // fill the fresh node first, splice neighbors next cycle
                    we.key     = 1'b1;
                    map_waddr  = nkey_reg[KW-1:0];
                    map_wdata  = fresh;
                    key_waddr  = fresh;
                    key_wdata  = nkey_reg;
                    prev_waddr = fresh;
                    prev_wdata = left_c;
                    next_waddr = fresh;
                    next_wdata = right_c;
                    state_next = ST_W2;
                end
            end
            ST_W2:
            begin
                we.prev    = 1'b1;
                we.next    = 1'b1;
                next_waddr = left_reg;
                next_wdata = fresh;
                prev_waddr = right_reg;
                prev_wdata = fresh;
                used_next  = fresh;
                state_next = ST_RESP;
            end
            ST_NBR:
            begin
                key_raddr  = (act_reg == kdl_pkg::ACT_ASK_NEXT) ? next_rdata : prev_rdata;
                state_next = ST_NBR2;
            end
            ST_NBR2:
            begin
                nb_next    = key_rdata;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            used_reg  <= used_next;
            if (state_reg == ST_RESP && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        anchor_reg <= anchor_next;
        nkey_reg   <= nkey_next;
        here_reg   <= here_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        sts_reg    <= sts_next;
        nb_reg     <= nb_next;
        if (state_reg == ST_RESP && rsp_free)
        begin
            rsp_status_reg <= sts_reg;
            rsp_nb_reg     <= nb_reg;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.neighbor_key = rsp_nb_reg;

endmodule

`default_nettype wire

[design/kdl_check.sv]
// port-level checks for the keyed doubly linked list, bound to the top level
`default_nettype none

module kdl_check (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       req_valid,
    input wire logic                       req_ready,
    input wire logic                       rsp_valid,
    input wire logic                       rsp_ready,
    input wire logic [kdl_pkg::STS_W-1:0]  rsp_status,
    input wire logic [kdl_pkg::KEY_W-1:0]  rsp_neighbor_key
);

    // a held response keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_neighbor_key))
    else $error("response changed while stalled");

    // one item at a time: no new item right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("ready stayed high after an accepted item");

    // a result needs at least a map read and a decision
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("response appeared too soon after an item");

    // rejected items never report a neighbor
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != kdl_pkg::STS_OK) |-> (rsp_neighbor_key == '0))
    else $error("neighbor key set on a rejected item");

endmodule

bind keyed_doubly_linked_list kdl_check u_kdl_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_neighbor_key (rsp.neighbor_key)
);

`default_nettype wire
